[design/mp2_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mp2_pkg
// Shared constants, types and register codes of the 2-D max pooling stream.
// ----------------------------------------------------------------------------
package mp2_pkg;

    // Sizing of the line store
    localparam int MAX_WIDTH    = 64;
    localparam int MAX_CHANNELS = 16;
    localparam int MAX_POOL     = 4;

    localparam int SLOT_W      = $clog2(MAX_POOL);
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int CH_W        = $clog2(MAX_CHANNELS);
    localparam int ADDR_W      = SLOT_W + COL_W + CH_W;
    localparam int STORE_DEPTH = MAX_POOL * MAX_WIDTH * MAX_CHANNELS;

    // Data and configuration port widths
    localparam int DATA_W    = 16;
    localparam int ROW_W     = 16;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;

    typedef logic signed [DATA_W-1:0] t_sample;

    localparam t_sample SAMPLE_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_HEIGHT  = 3'd0,
        CFG_IMAGE_WIDTH   = 3'd1,
        CFG_CHANNEL_COUNT = 3'd2,
        CFG_POOL_HEIGHT   = 3'd3,
        CFG_POOL_WIDTH    = 3'd4,
        CFG_STRIDE_ROWS   = 3'd5,
        CFG_STRIDE_COLS   = 3'd6
    } t_cfg_idx;

    // Effective (clamped) configuration
    typedef struct packed {
        logic [15:0] height;
        logic [6:0]  width;
        logic [4:0]  chans;
        logic [2:0]  pool_h;
        logic [2:0]  pool_w;
        logic [2:0]  stride_r;
        logic [2:0]  stride_c;
    } t_cfg;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_DRAIN,
        ST_OUT
    } t_state;

    // Controls from the sequencer to the store and the max unit
    typedef struct packed {
        logic              ram_we;
        logic [ADDR_W-1:0] ram_waddr;
        logic              ram_re;
        logic [ADDR_W-1:0] ram_raddr;
        logic              acc_clear;
        logic              acc_en;
    } t_ctl;

endpackage
`default_nettype wire

[design/mp2_in_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mp2_in_if
// Sample channel: valid/ready handshake carrying one input word.
// ----------------------------------------------------------------------------
interface mp2_in_if;
    import mp2_pkg::*;

    logic    valid;
    logic    ready;
    t_sample sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface
`default_nettype wire

[design/mp2_out_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mp2_out_if
// Result channel: valid/ready handshake carrying one pooled word.
// ----------------------------------------------------------------------------
interface mp2_out_if;
    import mp2_pkg::*;

    logic    valid;
    logic    ready;
    t_sample pooled;
    logic    last_of_image;

    modport source (output valid, output pooled, output last_of_image, input ready);
    modport sink   (input valid, input pooled, input last_of_image, output ready);
endinterface
`default_nettype wire

[design/mp2_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mp2_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module mp2_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

[design/mp2_cfg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mp2_cfg
// Configuration registers, clamping to usable values, and image restart.
// ----------------------------------------------------------------------------
module mp2_cfg (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [mp2_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [mp2_pkg::CFG_W-1:0]       i_cfg_data,
    output mp2_pkg::t_cfg                        o_cfg,
    output logic                                 o_restart
);
    import mp2_pkg::*;

    logic [15:0] r_height, n_height;
    logic [6:0]  r_width,  n_width;
    logic [4:0]  r_chans,  n_chans;
    logic [2:0]  r_pool_h, n_pool_h;
    logic [2:0]  r_pool_w, n_pool_w;
    logic [2:0]  r_str_r,  n_str_r;
    logic [2:0]  r_str_c,  n_str_c;

    // Register write decode; any valid index restarts the image
    always_comb begin
        n_height  = r_height;
        n_width   = r_width;
        n_chans   = r_chans;
        n_pool_h  = r_pool_h;
        n_pool_w  = r_pool_w;
        n_str_r   = r_str_r;
        n_str_c   = r_str_c;
        o_restart = 1'b0;
        if (i_cfg_we) begin
            o_restart = 1'b1;
            case (t_cfg_idx'(i_cfg_index))
                CFG_IMAGE_HEIGHT:  n_height = i_cfg_data[15:0];
                CFG_IMAGE_WIDTH:   n_width  = i_cfg_data[6:0];
                CFG_CHANNEL_COUNT: n_chans  = i_cfg_data[4:0];
                CFG_POOL_HEIGHT:   n_pool_h = i_cfg_data[2:0];
                CFG_POOL_WIDTH:    n_pool_w = i_cfg_data[2:0];
                CFG_STRIDE_ROWS:   n_str_r  = i_cfg_data[2:0];
                CFG_STRIDE_COLS:   n_str_c  = i_cfg_data[2:0];
                default:           o_restart = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_height <= 16'd1;
            r_width  <= 7'd1;
            r_chans  <= 5'd1;
            r_pool_h <= 3'd2;
            r_pool_w <= 3'd2;
            r_str_r  <= 3'd2;
            r_str_c  <= 3'd2;
        end else begin
            r_height <= n_height;
            r_width  <= n_width;
            r_chans  <= n_chans;
            r_pool_h <= n_pool_h;
            r_pool_w <= n_pool_w;
            r_str_r  <= n_str_r;
            r_str_c  <= n_str_c;
        end
    end

    // Zero acts as one; sizes cap at the store limits
    always_comb begin
        o_cfg.height = (r_height == 16'd0) ? 16'd1 : r_height;

        if (r_width == 7'd0)                      o_cfg.width = 7'd1;
        else if (r_width > 7'(MAX_WIDTH))         o_cfg.width = 7'(MAX_WIDTH);
        else                                      o_cfg.width = r_width;

        if (r_chans == 5'd0)                      o_cfg.chans = 5'd1;
        else if (r_chans > 5'(MAX_CHANNELS))      o_cfg.chans = 5'(MAX_CHANNELS);
        else                                      o_cfg.chans = r_chans;

        if (r_pool_h == 3'd0)                     o_cfg.pool_h = 3'd1;
        else if (r_pool_h > 3'(MAX_POOL))         o_cfg.pool_h = 3'(MAX_POOL);
        else                                      o_cfg.pool_h = r_pool_h;

        if (r_pool_w == 3'd0)                     o_cfg.pool_w = 3'd1;
        else if (r_pool_w > 3'(MAX_POOL))         o_cfg.pool_w = 3'(MAX_POOL);
        else                                      o_cfg.pool_w = r_pool_w;

        o_cfg.stride_r = (r_str_r == 3'd0) ? 3'd1 : r_str_r;
        o_cfg.stride_c = (r_str_c == 3'd0) ? 3'd1 : r_str_c;
    end

endmodule
`default_nettype wire

[design/mp2_max_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mp2_max_unit
// Shared signed compare unit: folds one store word per cycle, while enabled, into a maximum.
// ----------------------------------------------------------------------------
module mp2_max_unit (
    input  wire logic             i_clk,
    input  wire logic             i_clear,
    input  wire logic             i_en,
    input  wire mp2_pkg::t_sample i_data,
    output mp2_pkg::t_sample      o_max
);
    import mp2_pkg::*;

    t_sample r_best, n_best;

    // Clear to the most negative value, then keep the larger word
    always_comb begin
        n_best = r_best;
        if (i_clear) begin
            n_best = SAMPLE_MIN;
        end else if (i_en && (i_data > r_best)) begin
            n_best = i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_best <= n_best;
    end

    assign o_max = r_best;

endmodule
`default_nettype wire

[design/mp2_seq.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mp2_seq
// Raster position tracking, window detection and the window read sequencer.
// ----------------------------------------------------------------------------
module mp2_seq (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire mp2_pkg::t_cfg i_cfg,
    input  wire logic          i_restart,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output logic               o_last,
    output mp2_pkg::t_ctl      o_ctl
);
    import mp2_pkg::*;

    t_state r_state, n_state;

    // Raster position of the next sample
    logic [ROW_W-1:0] r_row, n_row;
    logic [COL_W-1:0] r_col, n_col;
    logic [CH_W-1:0]  r_ch,  n_ch;
    // Rows / columns left until the next window bottom / right edge
    logic [2:0]       r_rwait, n_rwait;
    logic [2:0]       r_cwait, n_cwait;

    // Window walk
    logic [SLOT_W-1:0] r_bslot, n_bslot;
    logic [COL_W-1:0]  r_bcol,  n_bcol;
    logic [CH_W-1:0]   r_wch,   n_wch;
    logic [SLOT_W-1:0] r_ri,    n_ri;
    logic [SLOT_W-1:0] r_ki,    n_ki;
    logic              r_last,  n_last;
    logic              r_rd_vld;

    logic [2:0] ph_m1, pw_m1;
    logic [2:0] eff_rwait, eff_cwait;
    logic       accept, hit;
    logic       ch_last, col_last, row_last;
    logic       row_fin, col_fin;
    logic       k_end, r_end;

    // Window detection for the current position
    always_comb begin
        ph_m1     = i_cfg.pool_h - 3'd1;
        pw_m1     = i_cfg.pool_w - 3'd1;
        eff_rwait = (r_row == '0) ? ph_m1 : r_rwait;
        eff_cwait = (r_col == '0) ? pw_m1 : r_cwait;
        hit       = (eff_rwait == 3'd0) && (eff_cwait == 3'd0);
        accept    = i_in_valid && o_in_ready;
        ch_last   = (5'(r_ch) == (i_cfg.chans - 5'd1));
        col_last  = (7'(r_col) == (i_cfg.width - 7'd1));
        row_last  = (r_row == (i_cfg.height - 16'd1));
        row_fin   = (17'(r_row) + 17'(i_cfg.stride_r)) >= 17'(i_cfg.height);
        col_fin   = (8'(r_col) + 8'(i_cfg.stride_c)) >= 8'(i_cfg.width);
        k_end     = (r_ki == pw_m1[SLOT_W-1:0]);
        r_end     = (r_ri == ph_m1[SLOT_W-1:0]);
    end

    // Position advance in channel, column, row order
    always_comb begin
        n_row   = r_row;
        n_col   = r_col;
        n_ch    = r_ch;
        n_rwait = r_rwait;
        n_cwait = r_cwait;
        if (i_restart) begin
            n_row = '0;
            n_col = '0;
            n_ch  = '0;
        end else if (accept) begin
            if (!ch_last) begin
                n_ch = r_ch + 1'b1;
            end else begin
                n_ch = '0;
                if (!col_last) begin
                    n_col   = r_col + 1'b1;
                    n_cwait = (eff_cwait == 3'd0) ? (i_cfg.stride_c - 3'd1)
                                                  : (eff_cwait - 3'd1);
                end else begin
                    n_col   = '0;
                    n_row   = row_last ? '0 : (r_row + 1'b1);
                    n_rwait = (eff_rwait == 3'd0) ? (i_cfg.stride_r - 3'd1)
                                                  : (eff_rwait - 3'd1);
                end
            end
        end
    end

    // Window capture and read counters
    always_comb begin
        n_bslot = r_bslot;
        n_bcol  = r_bcol;
        n_wch   = r_wch;
        n_last  = r_last;
        n_ri    = r_ri;
        n_ki    = r_ki;
        if (accept && hit) begin
            n_bslot = r_row[SLOT_W-1:0] - ph_m1[SLOT_W-1:0];
            n_bcol  = r_col - COL_W'(pw_m1);
            n_wch   = r_ch;
            n_last  = row_fin && col_fin && ch_last;
            n_ri    = '0;
            n_ki    = '0;
        end else if (r_state == ST_READ) begin
            if (k_end) begin
                n_ki = '0;
                n_ri = r_ri + 1'b1;
            end else begin
                n_ki = r_ki + 1'b1;
            end
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (accept && hit && !i_restart) n_state = ST_READ;
            ST_READ:  if (k_end && r_end) n_state = ST_DRAIN;
            ST_DRAIN: n_state = ST_OUT;
            ST_OUT:   if (i_out_ready) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        o_in_ready      = 1'b0;
        o_out_valid     = 1'b0;
        o_ctl.ram_re    = 1'b0;
        case (r_state)
            ST_IDLE:  o_in_ready   = 1'b1;
            ST_READ:  o_ctl.ram_re = 1'b1;
            ST_DRAIN: o_in_ready   = 1'b0;
            ST_OUT:   o_out_valid  = 1'b1;
            default:  o_in_ready   = 1'b0;
        endcase
        o_ctl.ram_we    = accept;
        o_ctl.ram_waddr = {r_row[SLOT_W-1:0], r_col, r_ch};
        o_ctl.ram_raddr = {r_bslot + r_ri, r_bcol + COL_W'(r_ki), r_wch};
        o_ctl.acc_clear = accept && hit;
        o_ctl.acc_en    = r_rd_vld;
        o_last          = r_last;
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_row    <= '0;
            r_col    <= '0;
            r_ch     <= '0;
            r_rwait  <= '0;
            r_cwait  <= '0;
            r_ri     <= '0;
            r_ki     <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_row    <= n_row;
            r_col    <= n_col;
            r_ch     <= n_ch;
            r_rwait  <= n_rwait;
            r_cwait  <= n_cwait;
            r_ri     <= n_ri;
            r_ki     <= n_ki;
            r_rd_vld <= (r_state == ST_READ);
        end
    end

    // Window payload registers
    always_ff @(posedge i_clk) begin
        r_bslot <= n_bslot;
        r_bcol  <= n_bcol;
        r_wch   <= n_wch;
        r_last  <= n_last;
    end

endmodule
`default_nettype wire

[design/max_pool_2d_stream.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// max_pool_2d_stream
// Absorbed sample: written into the line store on acceptance.
// Window-completing sample: ph*pw store reads, one per cycle, then a
// compare drain state; the result is then offered in the output state,
// and input is ready the cycle after it is taken.
// Synchronous active-low reset clears position and sequencer; no store clear.
// ----------------------------------------------------------------------------
module max_pool_2d_stream (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [mp2_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [mp2_pkg::CFG_W-1:0]     i_cfg_data,
    mp2_in_if.sink                             i_sample_ch,
    mp2_out_if.source                          o_pool_ch
);
    import mp2_pkg::*;

    t_cfg    cfg;
    t_ctl    ctl;
    logic    restart;
    logic    last;
    t_sample rd_data;
    t_sample best;

    // Configuration registers
    mp2_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg),
        .o_restart   (restart)
    );

    // Position tracking and window sequencer
    mp2_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_restart   (restart),
        .i_in_valid  (i_sample_ch.valid),
        .o_in_ready  (i_sample_ch.ready),
        .o_out_valid (o_pool_ch.valid),
        .i_out_ready (o_pool_ch.ready),
        .o_last      (last),
        .o_ctl       (ctl)
    );

    // Ring line store
    mp2_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ctl.ram_we),
        .i_waddr (ctl.ram_waddr),
        .i_wdata (i_sample_ch.sample),
        .i_re    (ctl.ram_re),
        .i_raddr (ctl.ram_raddr),
        .o_rdata (rd_data)
    );

    // Running maximum
    mp2_max_unit u_max (
        .i_clk   (i_clk),
        .i_clear (ctl.acc_clear),
        .i_en    (ctl.acc_en),
        .i_data  (rd_data),
        .o_max   (best)
    );

    assign o_pool_ch.pooled        = best;
    assign o_pool_ch.last_of_image = last;

endmodule
`default_nettype wire

[design/mp2_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mp2_checker
// Port-level checks of the pooling stream, bound to the top level.
// ----------------------------------------------------------------------------
module mp2_checker (
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             i_in_valid,
    input wire logic             i_in_ready,
    input wire logic             i_out_valid,
    input wire logic             i_out_ready,
    input wire mp2_pkg::t_sample i_pooled,
    input wire logic             i_last
);
    import mp2_pkg::*;

    // Stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_pooled) && $stable(i_last))
        else $error("result word changed while stalled");

    // No new sample taken while a result waits
    a_no_in_while_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !i_in_ready)
        else $error("input ready while result pending");

    // A result never appears the cycle right after a sample is taken
    a_no_instant_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_out_valid)
        else $error("result too soon after sample");

    // One result per window
    a_single_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready |=> !i_out_valid)
        else $error("result repeated");

    // Reset empties the result side
    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

endmodule

bind max_pool_2d_stream mp2_checker u_mp2_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_sample_ch.valid),
    .i_in_ready  (i_sample_ch.ready),
    .i_out_valid (o_pool_ch.valid),
    .i_out_ready (o_pool_ch.ready),
    .i_pooled    (o_pool_ch.pooled),
    .i_last      (o_pool_ch.last_of_image)
);
`default_nettype wire
